// ===== rtl/i2f_pkg.sv =====
// Shared types and constants for the integer-to-float converter.
// No dependencies.
package i2f_pkg;

  typedef enum logic [2:0] {
    RM_RNE = 3'd0,
    RM_RTZ = 3'd1,
    RM_RDN = 3'd2,
    RM_RUP = 3'd3,
    RM_RMM = 3'd4,
    RM_R5  = 3'd5,
    RM_R6  = 3'd6,
    RM_DYN = 3'd7
  } rm_e;

  localparam logic [1:0] FMT_SINGLE = 2'd0;
  localparam logic [1:0] FMT_DOUBLE = 2'd1;
  localparam logic [1:0] FMT_HALF   = 2'd2;
  localparam logic [1:0] FMT_NONE   = 2'd3;

  localparam logic [1:0] TYP_W  = 2'd0;
  localparam logic [1:0] TYP_WU = 2'd1;
  localparam logic [1:0] TYP_L  = 2'd2;
  localparam logic [1:0] TYP_LU = 2'd3;

  localparam logic       ACT_MOVE = 1'b0;

  localparam int unsigned FLAG_NX = 0;
  localparam int unsigned FLAG_OF = 2;

  localparam logic [63:0] BOX_SINGLE = 64'hFFFF_FFFF_0000_0000;
  localparam logic [63:0] BOX_HALF   = 64'hFFFF_FFFF_FFFF_0000;

  typedef struct packed {
    logic [63:0] source_value;
    logic [2:0]  instr_rounding;
    logic [1:0]  target_format;
    logic        action;
    logic [1:0]  source_type;
  } in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic [4:0]  fp_flags;
  } out_t;

  typedef struct packed {
    logic        sign;
    logic [63:0] norm;
    logic [5:0]  msb;
    logic        zero;
  } norm_t;

endpackage

// ===== rtl/i2f_norm.sv =====
// Operand magnitude, sign and left normalization (leading-zero shift).
// Depends on i2f_pkg.
module i2f_norm (
  input  logic [63:0]   src_i,
  input  logic [1:0]    typ_i,
  output i2f_pkg::norm_t norm_o
);

  logic [63:0] mag;
  logic        sign;
  logic [63:0] v [7];
  logic [5:0]  lz [7];

  always_comb begin
    sign = 1'b0;
    mag  = src_i;
    case (typ_i)
      i2f_pkg::TYP_W: begin
        sign = src_i[31];
        mag  = {32'd0, src_i[31] ? (32'd0 - src_i[31:0]) : src_i[31:0]};
      end
      i2f_pkg::TYP_WU: mag = {32'd0, src_i[31:0]};
      i2f_pkg::TYP_L: begin
        sign = src_i[63];
        mag  = src_i[63] ? (64'd0 - src_i) : src_i;
      end
      default: mag = src_i;
    endcase
  end

  // binary-search shift: 32, 16, 8, 4, 2, 1
  assign v[0]  = mag;
  assign lz[0] = '0;

  for (genvar k = 0; k < 6; k++) begin : g_shift
    localparam int unsigned Sh = 32 >> k;
    assign v[k+1]  = (v[k][63 -: Sh] == '0) ? (v[k] << Sh) : v[k];
    assign lz[k+1] = (v[k][63 -: Sh] == '0) ? (lz[k] | 6'(Sh)) : lz[k];
  end

  assign norm_o.sign = sign;
  assign norm_o.norm = v[6];
  assign norm_o.msb  = 6'd63 - lz[6];
  assign norm_o.zero = (mag == '0);

endmodule

// ===== rtl/i2f_round.sv =====
// Round and pack a normalized magnitude into one IEEE 754 format.
// Depends on i2f_pkg.
module i2f_round #(
  parameter int unsigned Prec  = 24,
  parameter int unsigned Ebits = 8
) (
  input  i2f_pkg::norm_t     norm_i,
  input  logic [2:0]         mode_i,
  output logic [Prec+Ebits-1:0] bits_o,
  output logic [4:0]         flags_o
);

  localparam int unsigned Bias = (1 << (Ebits - 1)) - 1;

  logic [Prec-1:0]  keep;
  logic             rnd;
  logic             sticky;
  logic             inc;
  logic [Prec:0]    sum;
  logic [6:0]       exp_r;
  logic             ovf;
  logic             to_inf;
  logic [Ebits-1:0] ef;

  assign keep   = norm_i.norm[63 -: Prec];
  assign rnd    = norm_i.norm[63-Prec];
  assign sticky = |norm_i.norm[62-Prec:0];

  always_comb begin
    case (mode_i)
      i2f_pkg::RM_RNE: inc = rnd & (sticky | keep[0]);
      i2f_pkg::RM_RDN: inc = (rnd | sticky) & norm_i.sign;
      i2f_pkg::RM_RUP: inc = (rnd | sticky) & ~norm_i.sign;
      i2f_pkg::RM_RMM: inc = rnd;
      default:         inc = 1'b0;
    endcase
    case (mode_i)
      i2f_pkg::RM_RNE, i2f_pkg::RM_RMM: to_inf = 1'b1;
      i2f_pkg::RM_RDN: to_inf = norm_i.sign;
      i2f_pkg::RM_RUP: to_inf = ~norm_i.sign;
      default:         to_inf = 1'b0;
    endcase
  end

  assign sum   = {1'b0, keep} + (Prec+1)'(inc);
  assign exp_r = {1'b0, norm_i.msb} + 7'(sum[Prec]);
  assign ovf   = 32'(exp_r) > Bias;
  assign ef    = Ebits'(32'(exp_r) + Bias);

  always_comb begin
    flags_o = '0;
    if (norm_i.zero) begin
      bits_o = '0;
    end else if (ovf) begin
      flags_o[i2f_pkg::FLAG_NX] = 1'b1;
      flags_o[i2f_pkg::FLAG_OF] = 1'b1;
      if (to_inf) bits_o = {norm_i.sign, {Ebits{1'b1}}, {(Prec-1){1'b0}}};
      else        bits_o = {norm_i.sign, {(Ebits-1){1'b1}}, 1'b0, {(Prec-1){1'b1}}};
    end else begin
      flags_o[i2f_pkg::FLAG_NX] = rnd | sticky;
      bits_o = {norm_i.sign, ef, sum[Prec] ? {(Prec-1){1'b0}} : sum[Prec-2:0]};
    end
  end

endmodule

// ===== rtl/int_to_float_convert.sv =====
// Integer-to-float conversion and raw move into a 64-bit FP register.
// Depends on i2f_pkg, i2f_norm, i2f_round.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low.
//   busy is always low: one transaction can enter every cycle.
//   Pipeline: input register, normalize register, result register.
//   The result appears on out_o with done_o high for exactly one cycle,
//   once it has passed the input, normalize and result registers;
//   throughput is one per cycle.
//   The receiver cannot stall; results are never held.
//   cfg channel writes the dynamic rounding mode (cfg_ready_o always high);
//   write it only while no transaction is in flight.
//   Reset clears the pipeline valid bits and the dynamic mode to RNE.
//   Half and single results are boxed with ones above the format width, except moves of a non-W type, which give zero.
//   Flags: inexact and overflow only.
module int_to_float_convert (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  i2f_pkg::in_t    in_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_data_i,
  output logic            done_o,
  output i2f_pkg::out_t   out_o
);

  logic [2:0]     dyn_q;
  logic           v1_q, v2_q, v3_q;
  i2f_pkg::in_t   in_q;
  logic [2:0]     mode_d, mode1_q, mode2_q;
  logic [1:0]     fmt2_q, typ2_q;
  logic           act2_q;
  logic [63:0]    src2_q;
  i2f_pkg::norm_t norm_d, norm_q;
  i2f_pkg::out_t  out_d, out_q;
  logic [15:0]    h_bits;
  logic [31:0]    s_bits;
  logic [63:0]    d_bits;
  logic [4:0]     h_fl, s_fl, d_fl;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = (in_i.instr_rounding == i2f_pkg::RM_DYN) ? dyn_q : in_i.instr_rounding;
    if (mode_d > i2f_pkg::RM_RMM) mode_d = i2f_pkg::RM_RTZ;
  end

  i2f_norm u_norm (
    .src_i  (in_q.source_value),
    .typ_i  (in_q.source_type),
    .norm_o (norm_d)
  );

  i2f_round #(.Prec(11), .Ebits(5)) u_half (
    .norm_i(norm_q), .mode_i(mode2_q), .bits_o(h_bits), .flags_o(h_fl)
  );
  i2f_round #(.Prec(24), .Ebits(8)) u_single (
    .norm_i(norm_q), .mode_i(mode2_q), .bits_o(s_bits), .flags_o(s_fl)
  );
  i2f_round #(.Prec(53), .Ebits(11)) u_double (
    .norm_i(norm_q), .mode_i(mode2_q), .bits_o(d_bits), .flags_o(d_fl)
  );

  always_comb begin
    out_d = '0;
    if (fmt2_q == i2f_pkg::FMT_NONE) begin
      out_d = '0;
    end else if (act2_q == i2f_pkg::ACT_MOVE) begin
      if (typ2_q == i2f_pkg::TYP_W) begin
        case (fmt2_q)
          i2f_pkg::FMT_SINGLE: out_d.result_bits = i2f_pkg::BOX_SINGLE | {32'd0, src2_q[31:0]};
          i2f_pkg::FMT_DOUBLE: out_d.result_bits = src2_q;
          default:             out_d.result_bits = i2f_pkg::BOX_HALF | {48'd0, src2_q[15:0]};
        endcase
      end
    end else begin
      case (fmt2_q)
        i2f_pkg::FMT_SINGLE: begin
          out_d.result_bits = i2f_pkg::BOX_SINGLE | {32'd0, s_bits};
          out_d.fp_flags    = s_fl;
        end
        i2f_pkg::FMT_DOUBLE: begin
          out_d.result_bits = d_bits;
          out_d.fp_flags    = d_fl;
        end
        default: begin
          out_d.result_bits = i2f_pkg::BOX_HALF | {48'd0, h_bits};
          out_d.fp_flags    = h_fl;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_q <= 3'd0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) dyn_q <= cfg_data_i;
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_i;
    mode1_q <= mode_d;
    norm_q  <= norm_d;
    mode2_q <= mode1_q;
    fmt2_q  <= in_q.target_format;
    typ2_q  <= in_q.source_type;
    act2_q  <= in_q.action;
    src2_q  <= in_q.source_value;
    out_q   <= out_d;
  end

  assign done_o = v3_q;
  assign out_o  = out_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3))
    else $error("result without matching transaction");
  a_ovf_nx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.fp_flags[i2f_pkg::FLAG_OF]) |-> out_o.fp_flags[i2f_pkg::FLAG_NX])
    else $error("overflow without inexact");
  a_ovf_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.fp_flags[i2f_pkg::FLAG_OF]) |-> (out_o.result_bits[63:16] == '1))
    else $error("overflow outside half format");
  a_move_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && $past(act2_q) == i2f_pkg::ACT_MOVE) |-> (out_o.fp_flags == '0))
    else $error("flags raised on move");
`endif

endmodule
